// ----- rtl/tked_pkg.sv -----
`timescale 1ns / 1ps

package tked_pkg;

    // Bytes of the escape sequences.
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
    localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'
    localparam logic [7:0] CH_E     = 8'h45;  // 'E'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;

    // Dense special key codes.
    localparam logic [7:0] KEY_UNKNOWN = 8'd0;
    localparam logic [7:0] KEY_UP      = 8'd1;
    localparam logic [7:0] KEY_HOME    = 8'd5;
    localparam logic [7:0] KEY_INSERT  = 8'd6;
    localparam logic [7:0] KEY_DELETE  = 8'd7;
    localparam logic [7:0] KEY_END     = 8'd8;
    localparam logic [7:0] KEY_PGUP    = 8'd9;
    localparam logic [7:0] KEY_PGDN    = 8'd10;
    localparam logic [7:0] KEY_F1      = 8'd11;
    localparam logic [7:0] KEY_F6      = 8'd16;
    localparam logic [7:0] KEY_F7      = 8'd17;
    localparam logic [7:0] KEY_F8      = 8'd18;
    localparam logic [7:0] KEY_F9      = 8'd19;
    localparam logic [7:0] KEY_F10     = 8'd20;
    localparam logic [7:0] KEY_F12     = 8'd21;

endpackage

// ----- rtl/terminal_escape_key_decoder.sv -----
`timescale 1ns / 1ps

// A byte that produces a key shows it on the master side in the cycle after its beat.
// Throughput: one byte per cycle; the output register lets a new byte in while a key
// waits, as long as the master side takes it in the same cycle.
// Bytes inside an escape sequence produce no output beat.
// Reset (i_rst_n low at a clock edge) returns the parser to idle and empties the output.
module terminal_escape_key_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] key_value
    output logic       m_axis_tuser    // [0] is_special
);
    import tked_pkg::*;

    // Parser states. The last ten wait for the closing tilde of a numbered key.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ESC,
        ST_CSI,
        ST_ONE,
        ST_TWO,
        ST_LBR,
        ST_T_DEL,
        ST_T_END,
        ST_T_PGUP,
        ST_T_PGDN,
        ST_T_F6,
        ST_T_F7,
        ST_T_F8,
        ST_T_F9,
        ST_T_F10,
        ST_T_F12
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic       n_emit;
    logic       n_special;
    logic [7:0] n_value;
    logic [7:0] tilde_key;
    logic       r_out_valid;
    logic       r_out_special;
    logic [7:0] r_out_value;
    logic       in_beat;
    logic [7:0] b;

    // The output register is free when empty or when its key leaves this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    // Key finished by a tilde in each waiting state.
    always_comb begin
        unique case (r_state)
            ST_T_DEL:  tilde_key = KEY_DELETE;
            ST_T_END:  tilde_key = KEY_END;
            ST_T_PGUP: tilde_key = KEY_PGUP;
            ST_T_PGDN: tilde_key = KEY_PGDN;
            ST_T_F6:   tilde_key = KEY_F6;
            ST_T_F7:   tilde_key = KEY_F7;
            ST_T_F8:   tilde_key = KEY_F8;
            ST_T_F9:   tilde_key = KEY_F9;
            ST_T_F10:  tilde_key = KEY_F10;
            ST_T_F12:  tilde_key = KEY_F12;
            default:   tilde_key = KEY_UNKNOWN;
        endcase
    end

    // One parser step. Any byte that breaks a sequence ends it with the unknown key,
    // so the default of every step is "emit unknown and go idle".
    always_comb begin
        n_state   = ST_IDLE;
        n_emit    = 1'b1;
        n_special = 1'b1;
        n_value   = KEY_UNKNOWN;
        unique case (r_state)
            ST_IDLE: begin
                if (b == CH_ESC) begin
                    n_state = ST_ESC;
                    n_emit  = 1'b0;
                end else begin
                    n_special = 1'b0;
                    n_value   = b;
                end
            end
            ST_ESC: begin
                if (b == CH_LBR) begin
                    n_state = ST_CSI;
                    n_emit  = 1'b0;
                end
            end
            ST_CSI: begin
                if (b >= CH_A && b <= CH_D) begin
                    n_value = KEY_UP + (b - CH_A);
                end else if (b == CH_1) begin
                    n_state = ST_ONE;
                    n_emit  = 1'b0;
                end else if (b == CH_2) begin
                    n_state = ST_TWO;
                    n_emit  = 1'b0;
                end else if (b == CH_3) begin
                    n_state = ST_T_DEL;
                    n_emit  = 1'b0;
                end else if (b == CH_4) begin
                    n_state = ST_T_END;
                    n_emit  = 1'b0;
                end else if (b == CH_5) begin
                    n_state = ST_T_PGUP;
                    n_emit  = 1'b0;
                end else if (b == CH_6) begin
                    n_state = ST_T_PGDN;
                    n_emit  = 1'b0;
                end else if (b == CH_LBR) begin
                    n_state = ST_LBR;
                    n_emit  = 1'b0;
                end
            end
            ST_ONE: begin
                if (b == CH_TILDE) begin
                    n_value = KEY_HOME;
                end else if (b == CH_7) begin
                    n_state = ST_T_F6;
                    n_emit  = 1'b0;
                end else if (b == CH_8) begin
                    n_state = ST_T_F7;
                    n_emit  = 1'b0;
                end else if (b == CH_9) begin
                    n_state = ST_T_F8;
                    n_emit  = 1'b0;
                end
            end
            ST_TWO: begin
                if (b == CH_TILDE) begin
                    n_value = KEY_INSERT;
                end else if (b == CH_0) begin
                    n_state = ST_T_F9;
                    n_emit  = 1'b0;
                end else if (b == CH_1) begin
                    n_state = ST_T_F10;
                    n_emit  = 1'b0;
                end else if (b == CH_4) begin
                    n_state = ST_T_F12;
                    n_emit  = 1'b0;
                end
            end
            ST_LBR: begin
                if (b >= CH_A && b <= CH_E) begin
                    n_value = KEY_F1 + (b - CH_A);
                end
            end
            default: begin
                if (b == CH_TILDE) begin
                    n_value = tilde_key;
                end
            end
        endcase
    end

    // Parser state and the output register. A key is loaded when its byte is taken;
    // otherwise the register empties once the master side takes its beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state <= n_state;
            end
            if (in_beat && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_beat && n_emit) begin
            r_out_special <= n_special;
            r_out_value   <= n_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_special;

endmodule

// ----- rtl/tked_checker.sv -----
`timescale 1ns / 1ps

module tked_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);
    import tked_pkg::*;

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat present after reset");

    // A stalled key holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // ESC always opens a sequence, so it never passes through as a plain key.
    a_no_plain_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != CH_ESC)
        else $error("ESC passed through as a plain key");

    // Special codes stay in the dense range.
    a_special_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata <= KEY_F12)
        else $error("special key code out of range");

    // An empty output never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

endmodule

bind terminal_escape_key_decoder tked_checker u_tked_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
